// ===== rtl/core/vlxfb_pkg.sv =====
// Shared types, constants and slot codes for the XOR checksum frame builder.
`timescale 1ns / 1ps

package vlxfb_pkg;

	// Frame constants
	localparam logic [7:0]  SYNC_A       = 8'hAA;
	localparam logic [7:0]  SYNC_B       = 8'hBB;
	localparam logic [7:0]  TRAILER_B    = 8'hCC;
	localparam logic [15:0] LEN_OVERHEAD = 16'd10;
	localparam int unsigned MAX_PAYLOAD  = 1024;

	// Register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_STATION = 1'b0,
		REG_BCD     = 1'b1
	} reg_idx_t;

	// One-hot byte slots within the words an item produces
	typedef enum logic [10:0] {
		SL_SYNC_A  = 11'b000_0000_0001,
		SL_SYNC_B  = 11'b000_0000_0010,
		SL_SEQ     = 11'b000_0000_0100,
		SL_ADDR_HI = 11'b000_0000_1000,
		SL_ADDR_LO = 11'b000_0001_0000,
		SL_LEN_HI  = 11'b000_0010_0000,
		SL_LEN_LO  = 11'b000_0100_0000,
		SL_DATA    = 11'b000_1000_0000,
		SL_TRL_A   = 11'b001_0000_0000,
		SL_TRL_B   = 11'b010_0000_0000,
		SL_SUM     = 11'b100_0000_0000
	} slot_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_item;
		logic        last_item;
		logic        no_payload;
		logic [10:0] payload_count;
		logic        use_sequence;
		logic [7:0]  sequence_number;
	} in_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} out_word_t;

	// Work planned for one accepted item
	typedef struct packed {
		slot_t       first_slot;
		logic        has_data;
		logic        has_trailer;
		logic [7:0]  data;
		logic [7:0]  seq;
		logic [15:0] len;
	} plan_t;

	// Address bytes as they go into the header
	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} addr_bytes_t;

endpackage

// ===== rtl/core/vlxfb_cfg.sv =====
// Register file and station address encoder (hex or packed BCD).
`timescale 1ns / 1ps

module vlxfb_cfg
	import vlxfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output addr_bytes_t       addr
);

	logic [15:0] station_q;
	logic        bcd_mode_q;
	reg_idx_t    reg_idx;
	logic        wr_en;

	logic [13:0] mod_d;
	logic [13:0] mod_s1;
	logic [26:0] prod;
	logic [6:0]  hund_s2;
	logic [13:0] mod_s2;
	logic [13:0] rem_full;
	logic [7:0]  bcd_hi_s3;
	logic [7:0]  bcd_lo_s3;

	// Two BCD digits of a value below one hundred
	function automatic logic [7:0] bcd_pair(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p    = 15'(v) * 15'd205;
		tens = p[14:11];
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q  <= '0;
			bcd_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_STATION: station_q  <= pwdata[15:0];
				REG_BCD:     bcd_mode_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_STATION: prdata = {{(DATA_W-16){1'b0}}, station_q};
			REG_BCD:     prdata = {{(DATA_W-1){1'b0}}, bcd_mode_q};
			default:     prdata = '0;
		endcase
	end

	// Reduce address modulo ten thousand
	always_comb begin
		if (station_q >= 16'd60000)      mod_d = 14'(station_q - 16'd60000);
		else if (station_q >= 16'd50000) mod_d = 14'(station_q - 16'd50000);
		else if (station_q >= 16'd40000) mod_d = 14'(station_q - 16'd40000);
		else if (station_q >= 16'd30000) mod_d = 14'(station_q - 16'd30000);
		else if (station_q >= 16'd20000) mod_d = 14'(station_q - 16'd20000);
		else if (station_q >= 16'd10000) mod_d = 14'(station_q - 16'd10000);
		else                             mod_d = 14'(station_q);
	end

	// Hundreds by reciprocal multiply, valid for values below ten thousand
	assign prod     = 27'(mod_s1) * 27'd5243;
	assign rem_full = mod_s2 - 14'(hund_s2) * 14'd100;

	// Encoder pipeline runs every cycle; after a write the BCD bytes settle through stages s1, s2 and s3
	always_ff @(posedge clk) begin
		mod_s1    <= mod_d;
		hund_s2   <= prod[25:19];
		mod_s2    <= mod_s1;
		bcd_hi_s3 <= bcd_pair(hund_s2);
		bcd_lo_s3 <= bcd_pair(rem_full[6:0]);
	end

	// Select header address bytes
	always_comb begin
		if (bcd_mode_q) begin
			addr.hi = bcd_hi_s3;
			addr.lo = bcd_lo_s3;
		end else begin
			addr.hi = station_q[15:8];
			addr.lo = station_q[7:0];
		end
	end

endmodule

// ===== rtl/core/vlxfb_intake.sv =====
// Input stage: frame tracking and per-item word plan register.
`timescale 1ns / 1ps

module vlxfb_intake
	import vlxfb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	input  logic     release_item,
	output logic     plan_valid,
	output plan_t    plan
);

	logic        in_frame_q;
	logic        valid_s1;
	plan_t       plan_s1;
	plan_t       plan_d;
	logic        produces;
	logic        in_frame_d;
	logic        accept;
	logic [15:0] count_sat;

	assign in_stall   = valid_s1 & ~release_item;
	assign accept     = in_valid & ~in_stall;
	assign plan_valid = valid_s1;
	assign plan       = plan_s1;

	// Work out which words this item yields
	always_comb begin
		if (32'(in_data.payload_count) > MAX_PAYLOAD) count_sat = 16'(MAX_PAYLOAD);
		else                                          count_sat = 16'(in_data.payload_count);
		if (in_data.no_payload && in_data.last_item)  count_sat = '0;

		plan_d.data = in_data.payload_byte;
		plan_d.seq  = in_data.use_sequence ? in_data.sequence_number : 8'h00;
		plan_d.len  = count_sat + LEN_OVERHEAD;

		if (in_data.first_item) begin
			plan_d.first_slot  = SL_SYNC_A;
			plan_d.has_data    = ~in_data.no_payload;
			plan_d.has_trailer = in_data.no_payload & in_data.last_item;
			produces           = 1'b1;
			in_frame_d         = ~(in_data.no_payload & in_data.last_item);
		end else begin
			plan_d.has_data    = ~in_data.no_payload;
			plan_d.has_trailer = in_data.last_item;
			plan_d.first_slot  = in_data.no_payload ? SL_TRL_A : SL_DATA;
			produces           = in_frame_q & (~in_data.no_payload | in_data.last_item);
			in_frame_d         = in_frame_q & ~in_data.last_item;
		end
	end

	// Track open frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
		end
	end

	// Hold the plan until its last word leaves; drop items that yield nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= produces;
		end else if (release_item) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produces) begin
			plan_s1 <= plan_d;
		end
	end

endmodule

// ===== rtl/core/vlxfb_emit.sv =====
// Word sequencer, running XOR and output register.
`timescale 1ns / 1ps

module vlxfb_emit
	import vlxfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        plan_valid,
	input  plan_t       plan,
	input  addr_bytes_t addr,
	output logic        release_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	slot_t      slot_q;
	logic       mid_q;
	logic [7:0] xor_q;
	logic       out_valid_q;
	out_word_t  out_q;

	slot_t      cur;
	slot_t      nxt;
	logic       done;
	logic       load;
	logic [7:0] byte_d;
	logic       end_d;

	assign cur          = mid_q ? slot_q : plan.first_slot;
	assign load         = plan_valid & (~out_valid_q | ~out_stall);
	assign release_item = load & done;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// Pick the word for the current slot and the slot after it
	always_comb begin
		byte_d = SYNC_A;
		end_d  = 1'b0;
		nxt    = SL_SYNC_A;
		done   = 1'b0;
		unique case (cur)
			SL_SYNC_A: begin
				byte_d = SYNC_A;
				nxt    = SL_SYNC_B;
			end
			SL_SYNC_B: begin
				byte_d = SYNC_B;
				nxt    = SL_SEQ;
			end
			SL_SEQ: begin
				byte_d = plan.seq;
				nxt    = SL_ADDR_HI;
			end
			SL_ADDR_HI: begin
				byte_d = addr.hi;
				nxt    = SL_ADDR_LO;
			end
			SL_ADDR_LO: begin
				byte_d = addr.lo;
				nxt    = SL_LEN_HI;
			end
			SL_LEN_HI: begin
				byte_d = plan.len[15:8];
				nxt    = SL_LEN_LO;
			end
			SL_LEN_LO: begin
				byte_d = plan.len[7:0];
				if (plan.has_data)         nxt = SL_DATA;
				else if (plan.has_trailer) nxt = SL_TRL_A;
				else                       done = 1'b1;
			end
			SL_DATA: begin
				byte_d = plan.data;
				if (plan.has_trailer) nxt = SL_TRL_A;
				else                  done = 1'b1;
			end
			SL_TRL_A: begin
				byte_d = SYNC_A;
				nxt    = SL_TRL_B;
			end
			SL_TRL_B: begin
				byte_d = TRAILER_B;
				nxt    = SL_SUM;
			end
			SL_SUM: begin
				byte_d = xor_q;
				end_d  = 1'b1;
				done   = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Advance through the slots of the held item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= 1'b0;
			slot_q <= SL_SYNC_A;
		end else if (load) begin
			mid_q  <= ~done;
			slot_q <= nxt;
		end
	end

	// Running XOR restarts on the first header word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= '0;
		end else if (load) begin
			if (cur == SL_SYNC_A)  xor_q <= byte_d;
			else if (end_d)        xor_q <= '0;
			else                   xor_q <= xor_q ^ byte_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.frame_byte <= byte_d;
			out_q.frame_end  <= end_d;
		end
	end

endmodule

// ===== rtl/core/variable_length_xor_frame_builder.sv =====
// Top level of the byte framer with XOR checksum.
// An accepted item is registered in the intake plan register; its first word loads the
// output register once that is empty or not stalled. The output gives one word per cycle
// unless it stalls; an item is held until the slot sequencer has loaded all its words (1
// for a payload byte, 7, 8 or 10 at frame start, 3 or 4 at frame end). Items that yield no
// word leave nothing behind and are taken at one per cycle while no item is held.
// BCD address bytes settle through the s1, s2 and s3 encoder stages after an address write.
// Reset clears the frame state, running XOR, handshakes and configuration registers.
`timescale 1ns / 1ps

module variable_length_xor_frame_builder
	import vlxfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	addr_bytes_t addr;
	plan_t       plan;
	logic        plan_valid;
	logic        release_item;

	vlxfb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.addr    (addr)
	);

	vlxfb_intake u_intake (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.release_item (release_item),
		.plan_valid   (plan_valid),
		.plan         (plan)
	);

	vlxfb_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.plan_valid   (plan_valid),
		.plan         (plan),
		.addr         (addr),
		.release_item (release_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule

// ===== rtl/core/vlxfb_checker.sv =====
// Port-level assertions for the frame builder, bound to the top level.
`timescale 1ns / 1ps

module vlxfb_assertions
	import vlxfb_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// Input stall only comes from held work, which must reach an empty output
	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> out_valid)
		else $error("held item not moved to empty output register");

	// A frame start keeps the input stalled while its header words go out
	a_header_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.first_item
		|=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
		else $error("header item released too early");

	// Two checksum words never come back to back; the trailer bytes part them
	a_end_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.frame_end
		|=> !(out_valid && out_data.frame_end))
		else $error("back-to-back frame end words");

endmodule

bind variable_length_xor_frame_builder vlxfb_assertions u_vlxfb_assertions (.*);
